/* design/onewire_rom_search_engine_defines.svh */
// Assertion macros of the 1-Wire ROM search engine, used by ors_rsp_queue.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef ONEWIRE_ROM_SEARCH_ENGINE_DEFINES_SVH
`define ONEWIRE_ROM_SEARCH_ENGINE_DEFINES_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ORS_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Checks that a consequence holds in the same cycle as its cause.
`define ORS_ASSERT_IMPL(label, cause, effect, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cause) |-> (effect)) \
      else $error(msg);

// Checks that a consequence holds in the cycle after its cause.
`define ORS_ASSERT_NEXT(label, cause, effect, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cause) |=> (effect)) \
      else $error(msg);

`endif

/* design/ors_pkg.sv */
// Types and constants of the 1-Wire ROM search engine.
// Used by ors_engine, ors_rsp_queue and onewire_rom_search_engine; no dependencies.
package ors_pkg;

   localparam int BRANCH_W   = 7;
   localparam int ROM_CODE_W = 64;
   localparam int COUNT_W    = 16;
   localparam int CSR_DATA_W = 16;
   localparam int BUNDLE_MAX = 3;

   localparam logic [BRANCH_W-1:0] NO_BRANCH      = 7'h7F;
   localparam logic [7:0]          SEARCH_CMD_RST = 8'hF0;
   localparam logic [COUNT_W-1:0]  COUNT_MAX      = 16'hFFFF;

   typedef enum logic [1:0] {
      CMD_START       = 2'd0,
      CMD_RESET_REPLY = 2'd1,
      CMD_BIT_PAIR    = 2'd2
   } command_type;

   typedef enum logic [2:0] {
      ACT_RESET_BUS  = 3'd0,
      ACT_SEND_CMD   = 3'd1,
      ACT_WRITE_BIT  = 3'd2,
      ACT_FOUND      = 3'd3,
      ACT_DONE       = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_COMPLETE  = 2'd0,
      ST_NO_DEVICE = 2'd1,
      ST_BUS_ERROR = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_RESET = 2'd1,
      PH_BITS  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      CSR_SEARCH_COMMAND = 2'd0,
      CSR_MAX_DEVICES    = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [1:0] command;
      logic       present;
      logic       bit_a;
      logic       bit_b;
   } req_type;

   typedef struct packed {
      logic [2:0]            action;
      logic [7:0]            command_byte;
      logic                  write_bit;
      logic [ROM_CODE_W-1:0] rom_code;
      logic [COUNT_W-1:0]    device_count;
      logic [1:0]            status;
      logic                  last;
   } rsp_type;

   // Up to three results caused by one input transaction, with shared payload.
   typedef struct packed {
      logic [1:0]                  count;
      action_type [BUNDLE_MAX-1:0] act;
      logic [7:0]                  command_byte;
      logic                        write_bit;
      logic [ROM_CODE_W-1:0]       rom_code;
      logic [COUNT_W-1:0]          device_count;
      status_type                  status;
   } bundle_type;

endpackage

/* design/ors_engine.sv */
// Search state and per-transaction decision logic of the 1-Wire ROM search.
// Depends on ors_pkg; feeds a result bundle to ors_rsp_queue.
module ors_engine
   import ors_pkg::*;
#(
   parameter int ROM_BITS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  req_type            req,
   input  logic [7:0]         search_command,
   input  logic [COUNT_W-1:0] max_devices,
   output bundle_type         bundle
);

   localparam int PW = $clog2(ROM_BITS);
   localparam logic [PW-1:0] LAST_IDX = PW'(ROM_BITS - 1);

   phase_type             phase_ff, phase_in;
   logic [ROM_BITS-1:0]   code_ff, code_in;
   logic [PW-1:0]         pos_ff, pos_in;
   logic [BRANCH_W-1:0]   branch_ff, branch_in;
   logic [BRANCH_W-1:0]   next_branch_ff, next_branch_in;
   logic                  final_ff, final_in;
   logic [COUNT_W-1:0]    found_ff, found_in;

   logic                  is_start, reply_ok, pair_ok, pair_err, zero_pair;
   logic [BRANCH_W-1:0]   idx_ext;
   logic                  take_branch, beyond, new_branch, wbit, last_bit;
   logic                  final_after, keep_going;
   logic [ROM_BITS-1:0]   code_upd;
   logic [COUNT_W-1:0]    found_inc;

   assign is_start    = req.command == CMD_START;
   assign reply_ok    = (req.command == CMD_RESET_REPLY) && (phase_ff == PH_RESET);
   assign pair_ok     = (req.command == CMD_BIT_PAIR) && (phase_ff == PH_BITS);
   assign pair_err    = req.bit_a && req.bit_b;
   assign zero_pair   = !req.bit_a && !req.bit_b;
   assign idx_ext     = BRANCH_W'(pos_ff);
   assign take_branch = branch_ff == idx_ext;
   assign beyond      = branch_ff[BRANCH_W-1] || (idx_ext > branch_ff);
   assign new_branch  = zero_pair && !take_branch && (beyond || !code_ff[pos_ff]);
   assign wbit        = zero_pair ? !new_branch : req.bit_a;
   assign last_bit    = pos_ff == LAST_IDX;
   assign final_after = final_ff && !new_branch;
   assign found_inc   = (found_ff == COUNT_MAX) ? found_ff : found_ff + COUNT_W'(1);
   assign keep_going  = !final_after &&
                        ((max_devices == '0) || (found_inc < max_devices));

   always_comb begin
      code_upd         = code_ff;
      code_upd[pos_ff] = wbit;
   end

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (is_start) begin
            phase_in = PH_RESET;
         end else if (reply_ok) begin
            phase_in = req.present ? PH_BITS : PH_IDLE;
         end else if (pair_ok) begin
            if (pair_err) begin
               phase_in = PH_IDLE;
            end else if (last_bit) begin
               phase_in = keep_going ? PH_RESET : PH_IDLE;
            end
         end
      end
   end

   always_comb begin
      code_in        = code_ff;
      pos_in         = pos_ff;
      branch_in      = branch_ff;
      next_branch_in = next_branch_ff;
      final_in       = final_ff;
      found_in       = found_ff;

      bundle              = '0;
      bundle.act[0]       = ACT_WRITE_BIT;
      bundle.act[1]       = ACT_FOUND;
      bundle.act[2]       = ACT_DONE;
      bundle.command_byte = search_command;
      bundle.write_bit    = wbit;
      bundle.rom_code     = ROM_CODE_W'(code_upd);
      bundle.device_count = found_inc;
      bundle.status       = ST_COMPLETE;

      if (accept) begin
         if (is_start) begin
            code_in        = '0;
            pos_in         = '0;
            branch_in      = NO_BRANCH;
            next_branch_in = NO_BRANCH;
            final_in       = 1'b0;
            found_in       = '0;
            bundle.count   = 2'd1;
            bundle.act[0]  = ACT_RESET_BUS;
         end else if (reply_ok) begin
            branch_in    = next_branch_ff;
            final_in     = 1'b1;
            bundle.count = 2'd1;
            if (req.present) begin
               pos_in        = '0;
               bundle.act[0] = ACT_SEND_CMD;
            end else begin
               found_in            = '0;
               bundle.act[0]       = ACT_DONE;
               bundle.device_count = '0;
               bundle.status       = ST_NO_DEVICE;
            end
         end else if (pair_ok) begin
            if (pair_err) begin
               bundle.count        = 2'd1;
               bundle.act[0]       = ACT_DONE;
               bundle.device_count = found_ff;
               bundle.status       = ST_BUS_ERROR;
            end else begin
               code_in  = code_upd;
               final_in = final_after;
               if (new_branch) begin
                  next_branch_in = idx_ext;
               end
               if (last_bit) begin
                  found_in     = found_inc;
                  bundle.count = 2'd3;
                  if (keep_going) begin
                     bundle.act[2] = ACT_RESET_BUS;
                  end
               end else begin
                  pos_in       = pos_ff + PW'(1);
                  bundle.count = 2'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         code_ff        <= '0;
         pos_ff         <= '0;
         branch_ff      <= NO_BRANCH;
         next_branch_ff <= NO_BRANCH;
         final_ff       <= 1'b0;
         found_ff       <= '0;
      end else begin
         phase_ff       <= phase_in;
         code_ff        <= code_in;
         pos_ff         <= pos_in;
         branch_ff      <= branch_in;
         next_branch_ff <= next_branch_in;
         final_ff       <= final_in;
         found_ff       <= found_in;
      end
   end

endmodule

/* design/ors_rsp_queue.sv */
// Result register that holds the results of one transaction and hands them out in order.
// Depends on ors_pkg and onewire_rom_search_engine_defines.svh.
`include "onewire_rom_search_engine_defines.svh"

module ors_rsp_queue
   import ors_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  bundle_type bundle,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   logic [1:0]                  cnt_ff, cnt_in;
   action_type [BUNDLE_MAX-1:0] act_ff, act_in;
   logic [7:0]                  cmd_ff;
   logic                        wbit_ff;
   logic [ROM_CODE_W-1:0]       rom_ff;
   logic [COUNT_W-1:0]          count_ff;
   status_type                  status_ff;
   logic                        accept, take, load;

   assign rsp_valid = cnt_ff != 2'd0;
   assign req_ready = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_ready);
   assign accept    = req_valid && req_ready;
   assign take      = rsp_valid && rsp_ready;
   assign load      = accept && (bundle.count != 2'd0);

   always_comb begin
      cnt_in = cnt_ff;
      act_in = act_ff;
      if (load) begin
         cnt_in = bundle.count;
         act_in = bundle.act;
      end else if (take) begin
         cnt_in    = cnt_ff - 2'd1;
         act_in[0] = act_ff[1];
         act_in[1] = act_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in;
      if (load) begin
         cmd_ff    <= bundle.command_byte;
         wbit_ff   <= bundle.write_bit;
         rom_ff    <= bundle.rom_code;
         count_ff  <= bundle.device_count;
         status_ff <= bundle.status;
      end
   end

   always_comb begin
      rsp_data              = '0;
      rsp_data.action       = act_ff[0];
      rsp_data.last         = cnt_ff == 2'd1;
      case (act_ff[0])
         ACT_SEND_CMD: begin
            rsp_data.command_byte = cmd_ff;
         end
         ACT_WRITE_BIT: begin
            rsp_data.write_bit = wbit_ff;
         end
         ACT_FOUND: begin
            rsp_data.rom_code = rom_ff;
         end
         ACT_DONE: begin
            rsp_data.device_count = count_ff;
            rsp_data.status       = status_ff;
         end
         default: begin
            rsp_data.action = act_ff[0];
         end
      endcase
   end

   `ORS_ASSERT_IMPL(a_no_accept_busy, cnt_ff > 2'd1, !req_ready, "accepted while results pending")
   `ORS_ASSERT_IMPL(a_bundle_size, accept, bundle.count != 2'd2, "illegal result count")
   `ORS_ASSERT_NEXT(a_load_count, load, cnt_ff == $past(bundle.count), "result count not loaded")
   `ORS_ASSERT_IMPL(a_found_not_last, rsp_valid && (act_ff[0] == ACT_FOUND), !rsp_data.last,
                    "device found ended a transaction")

endmodule

/* design/onewire_rom_search_engine.sv */
// Top level of the 1-Wire ROM search engine: configuration registers and channel wiring.
// Depends on ors_pkg, ors_engine and ors_rsp_queue.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid/req_ready    req_data (req_type)
//   rsp_      out        rsp_valid/rsp_ready    rsp_data (rsp_type)
//   csr_      in         csr_we, no wait        csr_index, csr_wdata
//
// A transaction is decided in the cycle it is accepted; its results appear from the next
// cycle on, one per cycle while rsp_ready is high: one to three depending on the step of
// the search, none for a command out of phase. The result register holds one transaction's
// results, so a new transaction is taken when it is empty or its last result is being
// delivered: one transaction per cycle if each causes one result and rsp_ready stays high.
// Reset is synchronous; no stall on the result side loses or repeats a result.
module onewire_rom_search_engine
   import ors_pkg::*;
#(
   parameter int ROM_BITS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [7:0]         search_command_ff;
   logic [COUNT_W-1:0] max_devices_ff;
   logic               accept;
   bundle_type         bundle;

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         search_command_ff <= SEARCH_CMD_RST;
         max_devices_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SEARCH_COMMAND: begin
               search_command_ff <= csr_wdata[7:0];
            end
            CSR_MAX_DEVICES: begin
               max_devices_ff <= csr_wdata[COUNT_W-1:0];
            end
            default: begin
               search_command_ff <= search_command_ff;
            end
         endcase
      end
   end

   ors_engine #(
      .ROM_BITS(ROM_BITS)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req            (req_data),
      .search_command (search_command_ff),
      .max_devices    (max_devices_ff),
      .bundle         (bundle)
   );

   ors_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .bundle    (bundle),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* tb/onewire_rom_search_engine_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the 1-Wire ROM search engine, driven through its
// request, result and register ports with a virtual bus of random devices.
// Depends on ors_pkg and onewire_rom_search_engine.
module onewire_rom_search_engine_tb;
   import ors_pkg::*;

   localparam int ROM_LEN = 64;
   localparam int MAX_DEV = 4;
   localparam int LIMIT = 400000;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_we;
   logic [1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   typedef struct {
      req_type stim;
      bit typed;
      rsp_type want;
   } row_type;

   row_type plan[$];
   rsp_type answers_due[$];
   int faults = 0;
   int taken = 0;
   int cycles = 0;
   bit tx_eager = 1'b0;
   bit rx_eager = 1'b0;

   // Search state as the engine should hold it.
   logic [63:0] rom_acc = '0;
   logic [5:0] bit_idx = '0;
   logic [6:0] branch_pt = NO_BRANCH;
   logic [6:0] next_branch_pt = NO_BRANCH;
   logic last_pass = 1'b0;
   logic [15:0] dev_found = '0;
   phase_type search_phase = PH_IDLE;
   logic [7:0] cfg_cmd = SEARCH_CMD_RST;
   logic [15:0] cfg_limit = '0;
   logic dir_bit;

   // Devices on the virtual bus and which of them still match this pass.
   logic [63:0] roster[MAX_DEV];
   bit alive[MAX_DEV];
   int roster_n = 0;

   onewire_rom_search_engine #(.ROM_BITS(ROM_LEN)) dut (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_we, .csr_index, .csr_wdata
   );

   always #5 clock = ~clock;

   function automatic rsp_type mk(action_type act, logic [7:0] cb, logic wb,
                                  logic [63:0] rom, logic [15:0] cnt, status_type st,
                                  logic fin);
      rsp_type r;
      r.action = act;
      r.command_byte = cb;
      r.write_bit = wb;
      r.rom_code = rom;
      r.device_count = cnt;
      r.status = st;
      r.last = fin;
      return r;
   endfunction

   // Applies one accepted transaction and queues the results it causes.
   function automatic int search_step(req_type r);
      int idx;
      int bp;
      logic [63:0] m;
      logic w;
      case (r.command)
         CMD_START: begin
            rom_acc = '0;
            bit_idx = '0;
            branch_pt = NO_BRANCH;
            next_branch_pt = NO_BRANCH;
            last_pass = 1'b0;
            dev_found = '0;
            search_phase = PH_RESET;
            answers_due.push_back(mk(ACT_RESET_BUS, 8'h00, 1'b0, '0, '0, ST_COMPLETE, 1'b1));
            return 1;
         end
         CMD_RESET_REPLY: begin
            if (search_phase != PH_RESET) return 0;
            branch_pt = next_branch_pt;
            last_pass = 1'b1;
            if (!r.present) begin
               dev_found = '0;
               search_phase = PH_IDLE;
               answers_due.push_back(mk(ACT_DONE, 8'h00, 1'b0, '0, '0, ST_NO_DEVICE, 1'b1));
            end else begin
               bit_idx = '0;
               search_phase = PH_BITS;
               answers_due.push_back(mk(ACT_SEND_CMD, cfg_cmd, 1'b0, '0, '0, ST_COMPLETE, 1'b1));
            end
            return 1;
         end
         CMD_BIT_PAIR: begin
            if (search_phase != PH_BITS) return 0;
            idx = bit_idx;
            bp = (branch_pt >= 7'd64) ? int'(branch_pt) - 128 : int'(branch_pt);
            m = 64'd1 << idx;
            if (r.bit_a && r.bit_b) begin
               search_phase = PH_IDLE;
               answers_due.push_back(mk(ACT_DONE, 8'h00, 1'b0, '0, dev_found, ST_BUS_ERROR,
                                        1'b1));
               return 1;
            end
            if (!r.bit_a && !r.bit_b) begin
               if (idx == bp) begin
                  w = 1'b1;
                  rom_acc |= m;
               end else if (idx > bp || (rom_acc & m) == 0) begin
                  w = 1'b0;
                  rom_acc &= ~m;
                  last_pass = 1'b0;
                  next_branch_pt = 7'(idx);
               end else begin
                  w = 1'b1;
               end
            end else begin
               w = r.bit_a;
               rom_acc = w ? (rom_acc | m) : (rom_acc & ~m);
            end
            dir_bit = w;
            if (idx < ROM_LEN - 1) begin
               bit_idx++;
               answers_due.push_back(mk(ACT_WRITE_BIT, 8'h00, w, '0, '0, ST_COMPLETE, 1'b1));
               return 1;
            end
            answers_due.push_back(mk(ACT_WRITE_BIT, 8'h00, w, '0, '0, ST_COMPLETE, 1'b0));
            answers_due.push_back(mk(ACT_FOUND, 8'h00, 1'b0, rom_acc, '0, ST_COMPLETE, 1'b0));
            if (dev_found != COUNT_MAX) dev_found++;
            if (!last_pass && (cfg_limit == 0 || dev_found < cfg_limit)) begin
               search_phase = PH_RESET;
               answers_due.push_back(mk(ACT_RESET_BUS, 8'h00, 1'b0, '0, '0, ST_COMPLETE, 1'b1));
            end else begin
               search_phase = PH_IDLE;
               answers_due.push_back(mk(ACT_DONE, 8'h00, 1'b0, '0, dev_found, ST_COMPLETE,
                                        1'b1));
            end
            return 3;
         end
         default: return 0;
      endcase
   endfunction

   task automatic mismatch(string what, logic [63:0] got, logic [63:0] want);
      faults++;
      $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
   endtask

   task automatic check_rsp(rsp_type got);
      rsp_type want;
      if (answers_due.size() == 0) begin
         mismatch("result with none due, action", got.action, '0);
         return;
      end
      want = answers_due.pop_front();
      if (got.action !== want.action) mismatch("action", got.action, want.action);
      if (got.command_byte !== want.command_byte)
         mismatch("command_byte", got.command_byte, want.command_byte);
      if (got.write_bit !== want.write_bit) mismatch("write_bit", got.write_bit, want.write_bit);
      if (got.rom_code !== want.rom_code) mismatch("rom_code", got.rom_code, want.rom_code);
      if (got.device_count !== want.device_count)
         mismatch("device_count", got.device_count, want.device_count);
      if (got.status !== want.status) mismatch("status", got.status, want.status);
      if (got.last !== want.last) mismatch("last", got.last, want.last);
   endtask

   task automatic offer(req_type r, output int n);
      int gap;
      if ($urandom_range(0, 29) == 0) tx_eager = !tx_eager;
      gap = tx_eager ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      n = search_step(r);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_engine(logic [7:0] cmd, logic [15:0] limit);
      csr_we <= 1'b1;
      csr_index <= CSR_SEARCH_COMMAND;
      csr_wdata <= {8'h00, cmd};
      @(posedge clock);
      cfg_cmd = cmd;
      csr_index <= CSR_MAX_DEVICES;
      csr_wdata <= limit;
      @(posedge clock);
      cfg_limit = limit;
      csr_we <= 1'b0;
   endtask

   task automatic pick_roster();
      logic [63:0] base;
      int style;
      base = {$urandom, $urandom};
      style = $urandom_range(0, 3);
      roster_n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, MAX_DEV - 1);
      for (int k = 0; k < roster_n; k++) begin
         case (style)
            0: roster[k] = {$urandom, $urandom};
            1: roster[k] = base ^ (64'd1 << $urandom_range(0, ROM_LEN - 1));
            2: roster[k] = base ^ (64'd1 << (ROM_LEN - 1 - k));
            default: roster[k] = (k == 0) ? '0 : ((k == 1) ? '1 : base);
         endcase
      end
   endtask

   function automatic void plan_row(logic [1:0] c, logic p, logic a, logic b, bit typed,
                                    rsp_type want);
      row_type row;
      row.stim = '{command: c, present: p, bit_a: a, bit_b: b};
      row.typed = typed;
      row.want = want;
      plan.push_back(row);
   endfunction

   initial begin
      while (cycles < LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin
      int gap;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (taken == 60) begin
            gap = 300;
         end else begin
            if ($urandom_range(0, 29) == 0) rx_eager = !rx_eager;
            gap = rx_eager ? 0 : $urandom_range(0, 10);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1 || rsp_ready !== 1'b1);
         check_rsp(rsp_data);
         taken++;
      end
   end

   initial begin
      req_type r;
      int n;
      int roll;
      int spot;
      int spent;
      int fault_at;
      logic [7:0] cmd_set[5];
      logic [15:0] limit_set[5];
      rsp_type reset_bus;
      rsp_type send_rst;
      rsp_type write_0;
      rsp_type write_1;

      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_SEARCH_COMMAND;
      csr_wdata = '0;
      fault_at = -1;
      cmd_set = '{8'h00, 8'hFF, 8'h00, 8'hA5, SEARCH_CMD_RST};
      cmd_set[2] = 8'($urandom);
      limit_set = '{16'd0, 16'd1, 16'hFFFF, 16'd2, 16'd0};

      reset_bus = mk(ACT_RESET_BUS, 8'h00, 1'b0, '0, '0, ST_COMPLETE, 1'b1);
      send_rst = mk(ACT_SEND_CMD, SEARCH_CMD_RST, 1'b0, '0, '0, ST_COMPLETE, 1'b1);
      write_0 = mk(ACT_WRITE_BIT, 8'h00, 1'b0, '0, '0, ST_COMPLETE, 1'b1);
      write_1 = mk(ACT_WRITE_BIT, 8'h00, 1'b1, '0, '0, ST_COMPLETE, 1'b1);
      plan_row(CMD_RESET_REPLY, 1, 1, 1, 0, '0);
      plan_row(CMD_BIT_PAIR, 1, 1, 1, 0, '0);
      plan_row(CMD_UNUSED, 1, 1, 1, 0, '0);
      plan_row(CMD_START, 1, 1, 1, 1, reset_bus);
      plan_row(CMD_RESET_REPLY, 0, 0, 0, 1,
               mk(ACT_DONE, 8'h00, 1'b0, '0, '0, ST_NO_DEVICE, 1'b1));
      plan_row(CMD_BIT_PAIR, 0, 0, 0, 0, '0);
      plan_row(CMD_START, 0, 0, 0, 1, reset_bus);
      plan_row(CMD_BIT_PAIR, 0, 0, 1, 0, '0);
      plan_row(CMD_RESET_REPLY, 1, 0, 0, 1, send_rst);
      plan_row(CMD_RESET_REPLY, 1, 0, 0, 0, '0);
      plan_row(CMD_UNUSED, 0, 0, 0, 0, '0);
      plan_row(CMD_BIT_PAIR, 0, 0, 1, 1, write_0);
      plan_row(CMD_BIT_PAIR, 0, 1, 0, 1, write_1);
      plan_row(CMD_BIT_PAIR, 0, 0, 0, 0, '0);
      plan_row(CMD_BIT_PAIR, 1, 0, 0, 0, '0);
      plan_row(CMD_BIT_PAIR, 0, 1, 1, 1,
               mk(ACT_DONE, 8'h00, 1'b0, '0, '0, ST_BUS_ERROR, 1'b1));
      plan_row(CMD_START, 1, 0, 1, 1, reset_bus);
      plan_row(CMD_RESET_REPLY, 1, 1, 0, 1, send_rst);
      plan_row(CMD_BIT_PAIR, 0, 1, 0, 1, write_1);
      plan_row(CMD_START, 0, 1, 1, 1, reset_bus);
      plan_row(CMD_RESET_REPLY, 1, 1, 1, 1, send_rst);
      plan_row(CMD_BIT_PAIR, 1, 1, 1, 1,
               mk(ACT_DONE, 8'h00, 1'b0, '0, '0, ST_BUS_ERROR, 1'b1));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         offer(plan[i].stim, n);
         if (plan[i].typed) begin
            void'(answers_due.pop_back());
            answers_due.push_back(plan[i].want);
         end
      end
      settle();

      for (int p = 0; p < 5; p++) begin
         program_engine(cmd_set[p], limit_set[p]);
         spent = 0;
         while (spent < 40 || search_phase != PH_IDLE) begin
            r = 5'($urandom);
            roll = $urandom_range(0, 999);
            spot = bit_idx;
            case (search_phase)
               PH_RESET: begin
                  if (roll < 30) begin
                     r.command = 2'($urandom_range(0, 3));
                  end else if (roll < 50) begin
                     r.command = CMD_START;
                  end else begin
                     r.command = CMD_RESET_REPLY;
                     r.present = (roster_n != 0) ^ (roll < 80);
                     for (int k = 0; k < MAX_DEV; k++) alive[k] = (k < roster_n);
                     fault_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, ROM_LEN - 1)
                                                            : -1;
                  end
               end
               PH_BITS: begin
                  if (roll < 3) begin
                     r.command = 2'($urandom_range(0, 3));
                  end else begin
                     r.command = CMD_BIT_PAIR;
                     r.bit_a = 1'b1;
                     r.bit_b = 1'b1;
                     if (spot != fault_at) begin
                        for (int k = 0; k < roster_n; k++) begin
                           if (alive[k]) begin
                              if (roster[k][spot]) r.bit_b = 1'b0;
                              else r.bit_a = 1'b0;
                           end
                        end
                     end
                  end
               end
               default: begin
                  if (roll < 100) begin
                     r.command = 2'($urandom_range(0, 3));
                  end else begin
                     r.command = CMD_START;
                     pick_roster();
                  end
               end
            endcase
            offer(r, n);
            if (n != 0) spent++;
            if (r.command == CMD_BIT_PAIR && n != 0 && !(r.bit_a && r.bit_b)) begin
               for (int k = 0; k < roster_n; k++)
                  if (roster[k][spot] != dir_bit) alive[k] = 0;
            end
         end
         settle();
      end

      repeat (8) @(posedge clock);
      if (faults == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
